### rtl/ttg_pkg.sv
// Shared types, constants and codes for the thermal throttle governor.
`timescale 1ns / 1ps

package ttg_pkg;

    localparam int TEMP_W    = 18;
    localparam int FREQ_W    = 22;
    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 4;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_LIMIT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_LIMIT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_MAX    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_MIN    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MIN = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MAX = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK    = 4'd7;

    // Register reset values
    localparam logic [TEMP_W-1:0] RST_SOFT_LIMIT  = 18'd85000;
    localparam logic [TEMP_W-1:0] RST_HARD_LIMIT  = 18'd95000;
    localparam logic [TEMP_W-1:0] RST_HYSTERESIS  = 18'd5000;
    localparam logic [FREQ_W-1:0] RST_SAFE_MAX    = 22'd1401600;
    localparam logic [FREQ_W-1:0] RST_SAFE_MIN    = 22'd652800;
    localparam logic [FREQ_W-1:0] RST_PROFILE_MIN = 22'd652800;
    localparam logic [FREQ_W-1:0] RST_PROFILE_MAX = 22'd2016000;

    typedef enum logic [1:0] {
        TS_OK        = 2'd0,
        TS_THROTTLED = 2'd1,
        TS_HARD      = 2'd2
    } t_therm;

    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_THROTTLE     = 4'd1,
        EV_OVR_ACTIVE   = 4'd2,
        EV_HARD         = 4'd3,
        EV_HARD_OVR_RST = 4'd4,
        EV_RECOVER      = 4'd5,
        EV_OVR_DENIED   = 4'd6,
        EV_OVR_SET      = 4'd7,
        EV_REJECTED     = 4'd8
    } t_event;

    typedef struct packed {
        logic              action;
        logic [TEMP_W-1:0] zone_temp_mc;
        logic              reading_ok;
        logic              last_zone;
        logic              override_value;
    } t_in_req;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_min_khz;
        logic [FREQ_W-1:0] freq_max_khz;
        logic [1:0]        thermal_state;
        logic              override_on;
        logic [TEMP_W-1:0] sweep_max_mc;
        logic [3:0]        event_code;
        logic              limits_changed;
    } t_out_rsp;

    // One queued unit of back-end work: an override request or a sweep end
    typedef struct packed {
        logic              is_req;
        logic              want;
        logic [TEMP_W-1:0] temp;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [TEMP_W-1:0] lim_soft_mc;
        logic [TEMP_W-1:0] lim_hard_mc;
        logic [TEMP_W-1:0] hysteresis;
        logic [FREQ_W-1:0] cap_max_khz;
        logic [FREQ_W-1:0] cap_min_khz;
        logic [FREQ_W-1:0] profile_min;
        logic [FREQ_W-1:0] profile_max;
        logic              fallback;
    } t_cfg;

endpackage

### rtl/ttg_front.sv
// Front end: accepts requests, folds readings into the running maximum, queues work.
`timescale 1ns / 1ps

module ttg_front
    import ttg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in_req i_req,
    output logic    o_push,
    output t_qent   o_ent
);

    logic [TEMP_W-1:0] r_run_max;
    logic [TEMP_W-1:0] n_run_max;
    logic [TEMP_W-1:0] w_cand;

    // Invalid readings leave the maximum alone
    assign w_cand = (i_req.reading_ok && (i_req.zone_temp_mc > r_run_max))
                    ? i_req.zone_temp_mc : r_run_max;

    always_comb begin
        n_run_max = r_run_max;
        if (i_accept && !i_req.action) begin
            n_run_max = i_req.last_zone ? '0 : w_cand;
        end
    end

    assign o_push       = i_accept && (i_req.action || i_req.last_zone);
    assign o_ent.is_req = i_req.action;
    assign o_ent.want   = i_req.override_value;
    assign o_ent.temp   = w_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max <= '0;
        end else begin
            r_run_max <= n_run_max;
        end
    end

endmodule

### rtl/ttg_queue.sv
// Small FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps

module ttg_queue
    import ttg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qent   i_ent,
    input  logic    i_pop,
    output t_qent   o_ent,
    output t_q_stat o_stat
);

    t_qent           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            w_do_push;
    logic            w_do_pop;

    assign o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_ent        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/ttg_back.sv
// Back end: configuration registers, thermal state machine, limits and result register.
`timescale 1ns / 1ps

module ttg_back
    import ttg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_qent                i_ent,
    input  t_q_stat              i_stat,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_rsp             o_out_data
);

    t_cfg              r_cfg;
    t_therm            r_state;
    t_therm            n_state;
    logic              r_override;
    logic              n_override;
    logic [TEMP_W-1:0] r_latched;
    logic [TEMP_W-1:0] n_latched;
    logic              r_out_valid;
    t_out_rsp          r_out;

    t_event            w_event;
    logic              w_changed;
    logic [FREQ_W-1:0] w_lo;
    logic [FREQ_W-1:0] w_hi;
    logic [TEMP_W-1:0] w_hard_rec;
    logic [TEMP_W-1:0] w_soft_rec;
    logic              w_hit_hard;
    logic              w_hit_soft;
    logic              w_below_hard_rec;
    logic              w_below_soft_rec;
    logic              w_reading;
    logic              w_request;

    assign o_pop       = !i_stat.empty && (!r_out_valid || !i_out_stall);
    assign w_request   = o_pop && i_ent.is_req;
    assign w_reading   = o_pop && !i_ent.is_req;

    // Recovery thresholds saturate at zero
    assign w_hard_rec = (r_cfg.lim_hard_mc > r_cfg.hysteresis)
                        ? (r_cfg.lim_hard_mc - r_cfg.hysteresis) : '0;
    assign w_soft_rec = (r_cfg.lim_soft_mc > r_cfg.hysteresis)
                        ? (r_cfg.lim_soft_mc - r_cfg.hysteresis) : '0;

    assign w_hit_hard       = (i_ent.temp >= r_cfg.lim_hard_mc);
    assign w_hit_soft       = (i_ent.temp >= r_cfg.lim_soft_mc);
    assign w_below_hard_rec = (i_ent.temp < w_hard_rec);
    assign w_below_soft_rec = (i_ent.temp < w_soft_rec);

    // Next state
    always_comb begin
        n_state    = r_state;
        n_override = r_override;
        n_latched  = r_latched;
        if (w_request) begin
            if (!r_cfg.fallback && !(i_ent.want && (r_state == TS_HARD))) begin
                n_override = i_ent.want;
            end
        end else if (w_reading) begin
            n_latched = i_ent.temp;
            if (w_hit_hard) begin
                if (r_state != TS_HARD) begin
                    n_state    = TS_HARD;
                    n_override = 1'b0;
                end
            end else if (w_hit_soft) begin
                if (r_state == TS_OK) begin
                    n_state = TS_THROTTLED;
                end
            end else if ((r_state == TS_HARD) && w_below_hard_rec) begin
                n_state = TS_OK;
            end else if ((r_state == TS_THROTTLED) && w_below_soft_rec) begin
                n_state = TS_OK;
            end
        end
    end

    // Event code and limits-changed flag
    always_comb begin
        w_event   = EV_NONE;
        w_changed = 1'b0;
        if (w_request) begin
            if (r_cfg.fallback) begin
                w_event = EV_REJECTED;
            end else if (i_ent.want && (r_state == TS_HARD)) begin
                w_event = EV_OVR_DENIED;
            end else begin
                w_event   = EV_OVR_SET;
                w_changed = 1'b1;
            end
        end else if (w_reading) begin
            if (w_hit_hard) begin
                if (r_state != TS_HARD) begin
                    w_event   = r_override ? EV_HARD_OVR_RST : EV_HARD;
                    w_changed = 1'b1;
                end
            end else if (w_hit_soft) begin
                if (r_state == TS_OK) begin
                    w_event   = r_override ? EV_OVR_ACTIVE : EV_THROTTLE;
                    w_changed = !r_override;
                end
            end else if (((r_state == TS_HARD) && w_below_hard_rec) ||
                         ((r_state == TS_THROTTLED) && w_below_soft_rec)) begin
                w_event   = EV_RECOVER;
                w_changed = 1'b1;
            end
        end
    end

    // Limits from the updated state
    always_comb begin
        w_lo = r_cfg.profile_min;
        w_hi = r_cfg.profile_max;
        case (n_state)
            TS_HARD: begin
                if (r_cfg.cap_max_khz < w_hi) begin
                    w_hi = r_cfg.cap_max_khz;
                end
                if (r_cfg.cap_min_khz < w_lo) begin
                    w_lo = r_cfg.cap_min_khz;
                end
            end
            TS_THROTTLED: begin
                if (!n_override && (r_cfg.cap_max_khz < w_hi)) begin
                    w_hi = r_cfg.cap_max_khz;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lim_soft_mc <= RST_SOFT_LIMIT;
            r_cfg.lim_hard_mc <= RST_HARD_LIMIT;
            r_cfg.hysteresis  <= RST_HYSTERESIS;
            r_cfg.cap_max_khz <= RST_SAFE_MAX;
            r_cfg.cap_min_khz <= RST_SAFE_MIN;
            r_cfg.profile_min <= RST_PROFILE_MIN;
            r_cfg.profile_max <= RST_PROFILE_MAX;
            r_cfg.fallback    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SOFT_LIMIT:  r_cfg.lim_soft_mc <= i_cfg_data[TEMP_W-1:0];
                REG_HARD_LIMIT:  r_cfg.lim_hard_mc <= i_cfg_data[TEMP_W-1:0];
                REG_HYSTERESIS:  r_cfg.hysteresis  <= i_cfg_data[TEMP_W-1:0];
                REG_SAFE_MAX:    r_cfg.cap_max_khz <= i_cfg_data[FREQ_W-1:0];
                REG_SAFE_MIN:    r_cfg.cap_min_khz <= i_cfg_data[FREQ_W-1:0];
                REG_PROFILE_MIN: r_cfg.profile_min <= i_cfg_data[FREQ_W-1:0];
                REG_PROFILE_MAX: r_cfg.profile_max <= i_cfg_data[FREQ_W-1:0];
                REG_FALLBACK:    r_cfg.fallback    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TS_OK;
            r_override  <= 1'b0;
            r_latched   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_override <= n_override;
            r_latched  <= n_latched;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.freq_min_khz   <= w_lo;
            r_out.freq_max_khz   <= w_hi;
            r_out.thermal_state  <= n_state;
            r_out.override_on    <= n_override;
            r_out.sweep_max_mc   <= n_latched;
            r_out.event_code     <= w_event;
            r_out.limits_changed <= w_changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/thermal_throttle_governor_core.sv
// Top level of the thermal throttle governor: front end, work queue, back end.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one request per cycle,
//   either a zone temperature reading or an override request. A request is
//   taken on a rising edge with i_in_valid high and o_in_stall low.
//   Readings that are not the last of a sweep only update the running maximum
//   and give no result. A sweep end or an override request gives one result.
//   Output channel (o_out_valid / i_out_stall / o_out_data): results leave in
//   request order from a registered output stage.
//   Throughput is one request per cycle while o_in_stall is low. The accepting
//   edge writes the work queue through the front end; a later edge runs the
//   back end state update, loads the output register and raises o_out_valid.
//   The four-entry work queue lets the front keep taking requests while the
//   receiver stalls; o_in_stall rises only when the queue is full.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) writes one register per
//   cycle; unknown indexes are dropped. Write only while the block is idle;
//   the block does not enforce it. Synchronous reset (i_rst_n low) restores
//   the register defaults, clears the running and latched maxima, the thermal
//   state and the override, and empties the queue and the output stage.

module thermal_throttle_governor_core
    import ttg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_req              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_rsp             o_out_data
);

    logic    w_accept;
    logic    w_push;
    logic    w_pop;
    t_qent   w_push_ent;
    t_qent   w_head_ent;
    t_q_stat w_q_stat;

    // Stall only on a full queue, so readings keep flowing while results wait
    assign o_in_stall = w_q_stat.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Classify and fold readings
    ttg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_req   (i_in_data),
        .o_push  (w_push),
        .o_ent   (w_push_ent)
    );

    // Hold work for the back end
    ttg_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_ent  (w_push_ent),
        .i_pop  (w_pop),
        .o_ent  (w_head_ent),
        .o_stat (w_q_stat)
    );

    // Advance the thermal state and build results
    ttg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ent      (w_head_ent),
        .i_stat     (w_q_stat),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

endmodule

### rtl/ttg_checker.sv
// Port-level checks for the thermal throttle governor and their bind.
`timescale 1ns / 1ps

module ttg_checker
    import ttg_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_rsp             o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    // Reset empties the output stage
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A granted override always recomputes limits
    a_ovr_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.event_code == EV_OVR_SET)) |->
        o_out_data.limits_changed)
        else $error("override set without limit update");

    // Hard state never carries the override
    a_hard_no_ovr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.thermal_state == TS_HARD)) |->
        !o_out_data.override_on)
        else $error("override on in hard state");

    // Without a sweep end or request nothing reaches an empty output after reset
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(!i_rst_n) && !i_in_valid) |=> !o_out_valid)
        else $error("result without request");

endmodule

bind thermal_throttle_governor_core ttg_checker u_ttg_checker (.*);

### bench/tb_top.sv
// Self-checking testbench for the thermal throttle governor core.
`timescale 1ns / 1ps

module tb_top;
    import ttg_pkg::*;

    // Request kinds carried in the action bit
    localparam logic ACT_READING  = 1'b0;
    localparam logic ACT_OVERRIDE = 1'b1;

    // Indexes past the last register; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = 4'd15;

    localparam int TEMP_TOP = 200000;
    localparam int FREQ_TOP = 4194303;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_req              i_in_data  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_rsp             o_out_data;

    thermal_throttle_governor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Governor shadow: register file and thermal state
    t_cfg              gov_regs;
    logic [TEMP_W-1:0] zone_run_max;
    logic [TEMP_W-1:0] zone_sweep_max;
    logic              soft_on;
    logic              hard_on;
    logic              override_set;

    t_out_rsp pending_limits[$];
    int       error_count = 0;
    bit       no_gaps     = 1'b0;

    function automatic bit take_break();
        return !no_gaps && ($urandom_range(0, 99) < 9);
    endfunction

    function automatic logic [TEMP_W-1:0] floor_sub(logic [TEMP_W-1:0] a, logic [TEMP_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        case (idx)
            REG_SOFT_LIMIT:  gov_regs.lim_soft_mc = d[TEMP_W-1:0];
            REG_HARD_LIMIT:  gov_regs.lim_hard_mc = d[TEMP_W-1:0];
            REG_HYSTERESIS:  gov_regs.hysteresis  = d[TEMP_W-1:0];
            REG_SAFE_MAX:    gov_regs.cap_max_khz = d[FREQ_W-1:0];
            REG_SAFE_MIN:    gov_regs.cap_min_khz = d[FREQ_W-1:0];
            REG_PROFILE_MIN: gov_regs.profile_min = d[FREQ_W-1:0];
            REG_PROFILE_MAX: gov_regs.profile_max = d[FREQ_W-1:0];
            REG_FALLBACK:    gov_regs.fallback    = d[0];
            default: ;
        endcase
    endfunction

    // Fold one accepted request into the shadow and queue the limits it yields
    function automatic void predict_limits(t_in_req r);
        t_event            ev;
        logic              chg;
        logic              gives;
        logic [TEMP_W-1:0] t;
        logic [FREQ_W-1:0] lo;
        logic [FREQ_W-1:0] hi;
        t_out_rsp          rsp;

        ev    = EV_NONE;
        chg   = 1'b0;
        gives = 1'b1;
        if (r.action == ACT_OVERRIDE) begin
            if (gov_regs.fallback) begin
                ev = EV_REJECTED;
            end else if (r.override_value && hard_on) begin
                ev = EV_OVR_DENIED;
            end else begin
                override_set = r.override_value;
                ev  = EV_OVR_SET;
                chg = 1'b1;
            end
        end else begin
            if (r.reading_ok && r.zone_temp_mc > zone_run_max)
                zone_run_max = r.zone_temp_mc;
            gives = r.last_zone;
            if (r.last_zone) begin
                t              = zone_run_max;
                zone_sweep_max = t;
                zone_run_max   = '0;
                if (t >= gov_regs.lim_hard_mc) begin
                    if (!hard_on) begin
                        hard_on = 1'b1;
                        soft_on = 1'b0;
                        // hard entry drops any override
                        ev = override_set ? EV_HARD_OVR_RST : EV_HARD;
                        override_set = 1'b0;
                        chg = 1'b1;
                    end
                end else if (t >= gov_regs.lim_soft_mc) begin
                    if (!soft_on && !hard_on) begin
                        soft_on = 1'b1;
                        ev  = override_set ? EV_OVR_ACTIVE : EV_THROTTLE;
                        chg = !override_set;
                    end
                end else if (hard_on && t < floor_sub(gov_regs.lim_hard_mc, gov_regs.hysteresis)) begin
                    hard_on = 1'b0;
                    soft_on = 1'b0;
                    ev  = EV_RECOVER;
                    chg = 1'b1;
                end else if (soft_on && t < floor_sub(gov_regs.lim_soft_mc, gov_regs.hysteresis)) begin
                    soft_on = 1'b0;
                    ev  = EV_RECOVER;
                    chg = 1'b1;
                end
            end
        end

        if (gives) begin
            lo = gov_regs.profile_min;
            hi = gov_regs.profile_max;
            if (hard_on) begin
                if (gov_regs.cap_max_khz < hi) hi = gov_regs.cap_max_khz;
                if (gov_regs.cap_min_khz < lo) lo = gov_regs.cap_min_khz;
            end else if (soft_on && !override_set) begin
                if (gov_regs.cap_max_khz < hi) hi = gov_regs.cap_max_khz;
            end
            rsp.freq_min_khz   = lo;
            rsp.freq_max_khz   = hi;
            rsp.thermal_state  = hard_on ? TS_HARD : (soft_on ? TS_THROTTLED : TS_OK);
            rsp.override_on    = override_set;
            rsp.sweep_max_mc   = zone_sweep_max;
            rsp.event_code     = ev;
            rsp.limits_changed = chg;
            pending_limits.push_back(rsp);
        end
    endfunction

    // Check each result as it leaves; sample mid-cycle so the edge decides nothing
    always @(negedge i_clk) begin
        t_out_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_limits.size() == 0) begin
                $error("unexpected result: %p", o_out_data);
                error_count++;
            end else begin
                want = pending_limits.pop_front();
                if (o_out_data.freq_min_khz !== want.freq_min_khz) begin
                    $error("freq_min_khz: expected %0d, got %0d",
                           want.freq_min_khz, o_out_data.freq_min_khz);
                    error_count++;
                end
                if (o_out_data.freq_max_khz !== want.freq_max_khz) begin
                    $error("freq_max_khz: expected %0d, got %0d",
                           want.freq_max_khz, o_out_data.freq_max_khz);
                    error_count++;
                end
                if (o_out_data.thermal_state !== want.thermal_state) begin
                    $error("thermal_state: expected %0d, got %0d",
                           want.thermal_state, o_out_data.thermal_state);
                    error_count++;
                end
                if (o_out_data.override_on !== want.override_on) begin
                    $error("override_on: expected %0d, got %0d",
                           want.override_on, o_out_data.override_on);
                    error_count++;
                end
                if (o_out_data.sweep_max_mc !== want.sweep_max_mc) begin
                    $error("sweep_max_mc: expected %0d, got %0d",
                           want.sweep_max_mc, o_out_data.sweep_max_mc);
                    error_count++;
                end
                if (o_out_data.event_code !== want.event_code) begin
                    $error("event_code: expected %0d, got %0d",
                           want.event_code, o_out_data.event_code);
                    error_count++;
                end
                if (o_out_data.limits_changed !== want.limits_changed) begin
                    $error("limits_changed: expected %0d, got %0d",
                           want.limits_changed, o_out_data.limits_changed);
                    error_count++;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= take_break();
    end

    // Present one request and hold it until taken; valid stays high for the next
    task automatic send_request(input t_in_req r);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        predict_limits(r);
    endtask

    task automatic send_reading(input int temp, input logic ok, input logic last);
        t_in_req r;
        r.action         = ACT_READING;
        r.zone_temp_mc   = temp[TEMP_W-1:0];
        r.reading_ok     = ok;
        r.last_zone      = last;
        r.override_value = 1'($urandom_range(0, 1));
        send_request(r);
    endtask

    task automatic send_override(input logic want);
        t_in_req r;
        r.action         = ACT_OVERRIDE;
        r.zone_temp_mc   = TEMP_W'($urandom_range(0, TEMP_TOP));
        r.reading_ok     = 1'($urandom_range(0, 1));
        r.last_zone      = 1'($urandom_range(0, 1));
        r.override_value = want;
        send_request(r);
    endtask

    // Drop valid, wait out every pending result, then let the pipe drain
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (pending_limits.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        store_reg(idx, d);
    endtask

    task automatic apply_settings(input t_cfg c);
        write_reg(REG_SOFT_LIMIT,  CFG_W'(c.lim_soft_mc));
        write_reg(REG_HARD_LIMIT,  CFG_W'(c.lim_hard_mc));
        write_reg(REG_HYSTERESIS,  CFG_W'(c.hysteresis));
        write_reg(REG_SAFE_MAX,    CFG_W'(c.cap_max_khz));
        write_reg(REG_SAFE_MIN,    CFG_W'(c.cap_min_khz));
        write_reg(REG_PROFILE_MIN, CFG_W'(c.profile_min));
        write_reg(REG_PROFILE_MAX, CFG_W'(c.profile_max));
        write_reg(REG_FALLBACK,    CFG_W'(c.fallback));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        int   base_mc;
        base_mc       = $urandom_range(20000, 150000);
        c.lim_soft_mc = TEMP_W'(base_mc);
        c.lim_hard_mc = TEMP_W'(base_mc + int'($urandom_range(0, 40000)));
        c.hysteresis  = TEMP_W'($urandom_range(0, 20000));
        c.cap_max_khz = FREQ_W'($urandom_range(1, FREQ_TOP));
        c.cap_min_khz = FREQ_W'($urandom_range(1, FREQ_TOP));
        c.profile_min = FREQ_W'($urandom_range(1, FREQ_TOP));
        c.profile_max = FREQ_W'($urandom_range(1, FREQ_TOP));
        c.fallback    = ($urandom_range(0, 3) == 0);
        return c;
    endfunction

    // Bias temperatures toward the current limits so transitions happen often
    function automatic int pick_temp();
        int sel;
        int spread;
        int centre;
        int v;
        sel    = $urandom_range(0, 9);
        spread = int'(gov_regs.hysteresis) + 2000;
        if (spread > 40000) spread = 40000;
        centre = (sel < 5) ? int'(gov_regs.lim_soft_mc) : int'(gov_regs.lim_hard_mc);
        v      = centre - spread + int'($urandom_range(0, 2 * spread));
        if (sel == 0) v = 0;
        else if (sel == 1) v = TEMP_TOP;
        else if (sel >= 8) v = int'($urandom_range(0, TEMP_TOP));
        if (v < 0) v = 0;
        if (v > TEMP_TOP) v = TEMP_TOP;
        return v;
    endfunction

    // Mostly whole sweeps with random content, some overrides and stray readings
    task automatic run_random_traffic(input int n_items);
        int sent;
        int kind;
        int zones;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                send_override(1'($urandom_range(0, 1)));
                sent++;
            end else if (kind < 20) begin
                send_reading(int'($urandom_range(0, TEMP_TOP)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                sent++;
            end else begin
                zones = $urandom_range(1, 5);
                for (int z = 0; z < zones; z++) begin
                    send_reading(pick_temp(), $urandom_range(0, 9) != 0, z == zones - 1);
                    sent++;
                end
            end
        end
    endtask

    // Walk ok -> throttled -> ok -> hard -> ok on the reset limits
    task automatic test_sweep_states();
        send_reading(TEMP_TOP, 1'b0, 1'b0);  // invalid, must not count
        send_reading(90000, 1'b1, 1'b0);
        send_reading(0, 1'b1, 1'b1);         // throttle on 90000
        send_reading(82000, 1'b1, 1'b1);     // inside the recovery band
        send_reading(79999, 1'b1, 1'b1);     // just below soft minus margin
        send_reading(95000, 1'b1, 1'b1);     // hard exactly at the limit
        send_reading(90000, 1'b1, 1'b1);     // soft band while hard: no change
        send_reading(TEMP_TOP, 1'b0, 1'b1);  // empty sweep evaluates to zero
    endtask

    task automatic test_override_rules();
        send_override(1'b1);
        send_reading(85000, 1'b1, 1'b1);     // throttle entry under override
        send_reading(100000, 1'b1, 1'b1);    // hard entry clears the override
        send_override(1'b1);                 // denied while hard
        send_override(1'b0);                 // clearing is still allowed
        send_reading(0, 1'b1, 1'b1);
    endtask

    task automatic test_register_writes();
        wait_for_idle();
        // High bits beyond the register width must be masked off
        write_reg(REG_SOFT_LIMIT, 22'h3C0000 | 22'd10000);
        write_reg(REG_HARD_LIMIT, 22'h3C0000 | 22'd20000);
        write_reg(REG_HYSTERESIS, 22'd30000);  // margin above both limits
        write_reg(REG_PAST_END, '1);
        write_reg(REG_TOP_IDX, '1);
        i_cfg_we <= 1'b0;
        send_reading(15000, 1'b1, 1'b1);     // throttle
        send_reading(0, 1'b1, 1'b1);         // threshold saturates: stay
        send_reading(25000, 1'b1, 1'b1);     // hard
        send_reading(0, 1'b1, 1'b1);         // still no way out
        wait_for_idle();
        write_reg(REG_FALLBACK, 22'd1);
        i_cfg_we <= 1'b0;
        send_override(1'b1);                 // rejected on fallback
    endtask

    task automatic test_config_phases();
        t_cfg c;
        wait_for_idle();
        c = '{lim_soft_mc: RST_SOFT_LIMIT, lim_hard_mc: RST_HARD_LIMIT,
              hysteresis: RST_HYSTERESIS, cap_max_khz: RST_SAFE_MAX,
              cap_min_khz: RST_SAFE_MIN, profile_min: RST_PROFILE_MIN,
              profile_max: RST_PROFILE_MAX, fallback: 1'b0};
        apply_settings(c);
        run_random_traffic(120);

        wait_for_idle();
        c = '{lim_soft_mc: 18'd0, lim_hard_mc: 18'd200000, hysteresis: 18'd0,
              cap_max_khz: 22'd1, cap_min_khz: 22'd4194303, profile_min: 22'd4194303,
              profile_max: 22'd1, fallback: 1'b0};
        apply_settings(c);
        run_random_traffic(100);

        wait_for_idle();
        c = '{lim_soft_mc: 18'd200000, lim_hard_mc: 18'd0, hysteresis: 18'd200000,
              cap_max_khz: 22'd4194303, cap_min_khz: 22'd1, profile_min: 22'd1,
              profile_max: 22'd4194303, fallback: 1'b1};
        apply_settings(c);
        run_random_traffic(80);

        repeat (3) begin
            wait_for_idle();
            apply_settings(random_settings());
            run_random_traffic(100);
        end
    endtask

    // Full rate on both sides for a long stretch
    task automatic test_back_to_back();
        wait_for_idle();
        apply_settings(random_settings());
        no_gaps = 1'b1;
        run_random_traffic(100);
        no_gaps = 1'b0;
    endtask

    initial begin
        gov_regs = '{lim_soft_mc: RST_SOFT_LIMIT, lim_hard_mc: RST_HARD_LIMIT,
                     hysteresis: RST_HYSTERESIS, cap_max_khz: RST_SAFE_MAX,
                     cap_min_khz: RST_SAFE_MIN, profile_min: RST_PROFILE_MIN,
                     profile_max: RST_PROFILE_MAX, fallback: 1'b0};
        zone_run_max   = '0;
        zone_sweep_max = '0;
        soft_on        = 1'b0;
        hard_on        = 1'b0;
        override_set   = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_sweep_states();
        test_override_rules();
        test_register_writes();
        test_config_phases();
        test_back_to_back();

        // Drain with a bound, then give stray results a chance to show up
        i_in_valid <= 1'b0;
        for (int k = 0; k < 2000 && pending_limits.size() != 0; k++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_limits.size() != 0) begin
            $error("%0d expected results never arrived", pending_limits.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("thermal_throttle_governor_core regression: pass");
        end else begin
            $display("thermal_throttle_governor_core regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("thermal_throttle_governor_core regression: fail");
        $finish;
    end

endmodule
